// ----- hdl/clce_pkg.sv -----
package clce_pkg;

    // Default sizes of the ring
    localparam int CAPACITY_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    // Fixed field widths on the stream ports
    localparam int CMD_BITS    = 3;
    localparam int STATUS_BITS = 2;
    localparam int DATA_BITS   = 32;
    localparam int COUNT_BITS  = 6;

    // Request commands (codes above CMD_DUMP are ignored)
    typedef enum logic [CMD_BITS-1:0] {
        CMD_INSERT = 3'd0,
        CMD_FIND   = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_STEP   = 3'd3,
        CMD_DUMP   = 3'd4
    } t_cmd;

    // Result status codes
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // Move that every cell of the ring makes in one cycle
    typedef enum logic [3:0] {
        OP_HOLD   = 4'b0001,
        OP_ROTATE = 4'b0010,
        OP_SHIFT  = 4'b0100,
        OP_INSERT = 4'b1000
    } t_cell_op;

endpackage

// ----- hdl/circular_list_cursor_engine_unit.sv -----
// Circular list with a cursor, kept as a row of CAPACITY cells in ring order:
// cell 0 is the cursor node and cell k its k-th successor, so moving the
// cursor rotates the occupied cells by one position per cycle. A request
// carries the command in s_axis tuser and the value or key in s_axis tdata.
// Insert, step, ignored commands and any command on an empty list finish
// in the accept cycle. Find and remove compare the cursor cell with
// the key once per cycle while the ring rotates, stopping at a match or
// after all n nodes. Dump sends n results, one per cycle. A stalled result
// output stalls the walk. One request is worked at a time; the next is taken
// once the last result is registered and the result register is empty or
// being read in that cycle.
module circular_list_cursor_engine_unit #(
    parameter int CAPACITY   = clce_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = clce_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    input  logic [2:0]  i_s_axis_tuser,   // [2:0] cmd
    // result side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] data, [37:32] count, [39:38] zero
    output logic [1:0]  o_m_axis_tuser,   // [1:0] status
    output logic        o_m_axis_tlast    // last
);

    localparam int CNT_BITS = $clog2(CAPACITY + 1);
    localparam int DW       = clce_pkg::DATA_BITS;
    localparam int CW       = clce_pkg::COUNT_BITS;
    localparam logic [CNT_BITS-1:0] CAP_C = CNT_BITS'(CAPACITY);
    localparam logic [CNT_BITS-1:0] ONE   = CNT_BITS'(1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

    t_state                  r_state, n_state;
    logic [CNT_BITS-1:0]     r_count, n_count;
    logic [CNT_BITS-1:0]     r_left, n_left;
    logic [VALUE_BITS-1:0]   r_key, n_key;
    clce_pkg::t_cmd          r_cmd, n_cmd;

    logic                    r_out_valid;
    clce_pkg::t_status       r_out_status;
    logic [DW-1:0]           r_out_data;
    logic [CW-1:0]           r_out_count;
    logic                    r_out_last;

    logic                    w_load;
    clce_pkg::t_status       w_status;
    logic [DW-1:0]           w_data;
    logic [CNT_BITS-1:0]     w_count_after;
    logic                    w_last;

    clce_pkg::t_cell_op      w_op;
    logic [VALUE_BITS-1:0]   w_cell [CAPACITY];
    logic [VALUE_BITS-1:0]   w_next [CAPACITY];
    logic [VALUE_BITS-1:0]   w_in_value;
    logic [VALUE_BITS-1:0]   w_succ;
    logic                    w_out_free;
    logic                    w_s_acc;
    logic                    w_match;

    // Ring of cells, each taking from its upper neighbor
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g < CAPACITY - 1) begin : g_link
            assign w_next[g] = w_cell[g + 1];
        end else begin : g_end
            assign w_next[g] = '0;
        end

        clce_cell #(
            .VALUE_BITS (VALUE_BITS),
            .CNT_BITS   (CNT_BITS),
            .INDEX      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_count (r_count),
            .i_next  (w_next[g]),
            .i_head  (w_cell[0]),
            .i_new   (w_in_value),
            .o_value (w_cell[g])
        );
    end

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_s_acc         = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_value      = VALUE_BITS'($signed(i_s_axis_tdata));
    assign w_succ          = (r_count == ONE) ? w_cell[0] : w_cell[1];
    assign w_match         = (w_cell[0] == r_key);

    // Sequence requests and drive the ring
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_left        = r_left;
        n_key         = r_key;
        n_cmd         = r_cmd;
        w_op          = clce_pkg::OP_HOLD;
        w_load        = 1'b0;
        w_status      = clce_pkg::ST_OK;
        w_data        = '0;
        w_count_after = r_count;
        w_last        = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (w_s_acc) begin
                    w_load = 1'b1;
                    unique case (i_s_axis_tuser)
                        clce_pkg::CMD_INSERT: begin
                            if (r_count == CAP_C) begin
                                w_status = clce_pkg::ST_FULL;
                            end else begin
                                w_op          = clce_pkg::OP_INSERT;
                                n_count       = r_count + ONE;
                                w_count_after = r_count + ONE;
                                w_data        = DW'($signed(w_in_value));
                            end
                        end
                        clce_pkg::CMD_FIND, clce_pkg::CMD_REMOVE,
                        clce_pkg::CMD_DUMP: begin
                            if (r_count == '0) begin
                                w_status = clce_pkg::ST_EMPTY;
                            end else begin
                                // defer the result to the walk
                                w_load  = 1'b0;
                                n_state = S_WALK;
                                n_left  = r_count;
                                n_key   = w_in_value;
                                n_cmd   = clce_pkg::t_cmd'(i_s_axis_tuser);
                            end
                        end
                        clce_pkg::CMD_STEP: begin
                            if (r_count == '0) begin
                                w_status = clce_pkg::ST_EMPTY;
                            end else begin
                                w_op   = clce_pkg::OP_ROTATE;
                                w_data = DW'($signed(w_succ));
                            end
                        end
                        default: begin
                            w_status = clce_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (w_out_free) begin
                    unique case (r_cmd)
                        clce_pkg::CMD_DUMP: begin
                            w_load = 1'b1;
                            w_op   = clce_pkg::OP_ROTATE;
                            w_data = DW'($signed(w_cell[0]));
                            w_last = (r_left == ONE);
                            if (r_left == ONE) begin
                                n_state = S_IDLE;
                            end else begin
                                n_left = r_left - ONE;
                            end
                        end
                        clce_pkg::CMD_FIND, clce_pkg::CMD_REMOVE: begin
                            if (w_match) begin
                                w_load  = 1'b1;
                                n_state = S_IDLE;
                                if (r_cmd == clce_pkg::CMD_FIND) begin
                                    w_data = DW'($signed(r_key));
                                end else begin
                                    // unlink the cursor node, successor becomes cursor
                                    w_op          = clce_pkg::OP_SHIFT;
                                    n_count       = r_count - ONE;
                                    w_count_after = r_count - ONE;
                                    w_data        = (r_count == ONE) ? '0
                                                  : DW'($signed(w_cell[1]));
                                end
                            end else begin
                                w_op = clce_pkg::OP_ROTATE;
                                if (r_left == ONE) begin
                                    w_load   = 1'b1;
                                    w_status = clce_pkg::ST_NOT_FOUND;
                                    n_state  = S_IDLE;
                                end else begin
                                    n_left = r_left - ONE;
                                end
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request payload and result register
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_cmd <= n_cmd;
        if (w_load) begin
            r_out_status <= w_status;
            r_out_data   <= w_data;
            r_out_count  <= CW'(w_count_after);
            r_out_last   <= w_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_count, r_out_data};
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

    // Checks on the sequencer
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("element count above capacity");

    a_no_accept_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> !o_s_axis_tready)
        else $error("request taken during a walk");

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_left != '0) && (r_left <= r_count))
        else $error("walk counter out of range");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && (i_s_axis_tuser == clce_pkg::CMD_INSERT) && (r_count != CAP_C))
        |=> (r_count == $past(r_count) + ONE))
        else $error("insert did not grow the ring");

    a_walk_ends_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && n_state == S_IDLE) |-> (w_load && w_last))
        else $error("walk ended without a final result");

endmodule

// ----- hdl/clce_cell.sv -----
// One ring position. Cell 0 holds the cursor node, cell k its k-th successor.
module clce_cell #(
    parameter int VALUE_BITS = clce_pkg::VALUE_BITS_DEF,
    parameter int CNT_BITS   = $clog2(clce_pkg::CAPACITY_DEF + 1),
    parameter int INDEX      = 0
) (
    input  logic                    i_clk,
    input  clce_pkg::t_cell_op      i_op,
    input  logic [CNT_BITS-1:0]     i_count,
    input  logic [VALUE_BITS-1:0]   i_next,
    input  logic [VALUE_BITS-1:0]   i_head,
    input  logic [VALUE_BITS-1:0]   i_new,
    output logic [VALUE_BITS-1:0]   o_value
);

    localparam logic [CNT_BITS-1:0] POS      = CNT_BITS'(INDEX);
    localparam logic [CNT_BITS-1:0] POS_NEXT = CNT_BITS'(INDEX + 1);

    logic [VALUE_BITS-1:0] r_value;
    logic [VALUE_BITS-1:0] n_value;

    // Pick the next value from the neighbor, the head or the new request
    always_comb begin
        n_value = r_value;
        unique case (i_op)
            clce_pkg::OP_HOLD: begin
                n_value = r_value;
            end
            clce_pkg::OP_ROTATE: begin
                // the last occupied cell takes the old head, the rest move down
                n_value = (i_count == POS_NEXT) ? i_head : i_next;
            end
            clce_pkg::OP_SHIFT: begin
                n_value = i_next;
            end
            clce_pkg::OP_INSERT: begin
                if (INDEX == 0) begin
                    n_value = i_new;
                end else if (i_count == POS) begin
                    n_value = i_head;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    localparam int RING_CAP  = clce_pkg::CAPACITY_DEF;
    localparam int CMD_W     = clce_pkg::CMD_BITS;
    localparam int DATA_W    = clce_pkg::DATA_BITS;
    localparam int COUNT_W   = clce_pkg::COUNT_BITS;
    localparam int RUN_LIMIT = 400000;
    localparam int TAIL_WAIT = 100;
    localparam int MAX_SHOWN = 60;

    // One request as queued for the driver
    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] value;
        bit                drain_first;
    } t_req_item;

    // One result as the block should send it
    typedef struct {
        clce_pkg::t_status  status;
        logic [DATA_W-1:0]  data;
        logic [COUNT_W-1:0] count;
        logic               last;
    } t_ring_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;
    logic [2:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    t_req_item         pending_reqs[$];
    t_ring_result      ring_results[$];
    logic [DATA_W-1:0] ring_vals[$];   // index 0 is the cursor node

    int  cycle_count = 0;
    int  reqs_taken = 0;
    int  results_seen = 0;
    int  mismatches = 0;
    int  ring_peak = 0;
    int  full_rejects = 0;
    bit  req_accepted = 1'b0;
    bit  quiet;

    circular_list_cursor_engine_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // No idling on either side for a stretch of requests in the middle
    assign quiet = (reqs_taken >= 120) && (reqs_taken < 200);

    function automatic bit idle_roll();
        return !quiet && (($urandom % 100) < 31);
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("mismatch on result %0d: %s", results_seen, what);
    endtask

    task automatic push_result(input clce_pkg::t_status status,
                               input logic [DATA_W-1:0] data, input logic last);
        t_ring_result r;
        r.status = status;
        r.data   = data;
        r.count  = COUNT_W'(ring_vals.size());
        r.last   = last;
        ring_results.push_back(r);
    endtask

    // Advance the ring state by one request and queue the results it causes
    task automatic ring_apply(input logic [CMD_W-1:0] cmd,
                              input logic [DATA_W-1:0] key);
        int n;
        int hit;
        n = ring_vals.size();
        hit = -1;
        if (cmd == clce_pkg::CMD_INSERT) begin
            if (n >= RING_CAP) begin
                full_rejects++;
                push_result(clce_pkg::ST_FULL, '0, 1'b1);
            end else begin
                // new node goes after the cursor and becomes the cursor
                if (n != 0)
                    ring_vals.push_back(ring_vals.pop_front());
                ring_vals.push_front(key);
                if (ring_vals.size() > ring_peak)
                    ring_peak = ring_vals.size();
                push_result(clce_pkg::ST_OK, key, 1'b1);
            end
        end else if (cmd > clce_pkg::CMD_DUMP) begin
            push_result(clce_pkg::ST_OK, '0, 1'b1);
        end else if (n == 0) begin
            push_result(clce_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
            // walk for the key; a miss brings the cursor back to its start
            if (cmd == clce_pkg::CMD_FIND || cmd == clce_pkg::CMD_REMOVE) begin
                for (int i = 0; i < n; i++) begin
                    if (ring_vals[0] == key) begin
                        hit = i;
                        break;
                    end
                    ring_vals.push_back(ring_vals.pop_front());
                end
            end
            case (cmd)
                clce_pkg::CMD_FIND: begin
                    if (hit < 0)
                        push_result(clce_pkg::ST_NOT_FOUND, '0, 1'b1);
                    else
                        push_result(clce_pkg::ST_OK, key, 1'b1);
                end
                clce_pkg::CMD_REMOVE: begin
                    if (hit < 0) begin
                        push_result(clce_pkg::ST_NOT_FOUND, '0, 1'b1);
                    end else begin
                        void'(ring_vals.pop_front());
                        if (ring_vals.size() == 0)
                            push_result(clce_pkg::ST_OK, '0, 1'b1);
                        else
                            push_result(clce_pkg::ST_OK, ring_vals[0], 1'b1);
                    end
                end
                clce_pkg::CMD_STEP: begin
                    ring_vals.push_back(ring_vals.pop_front());
                    push_result(clce_pkg::ST_OK, ring_vals[0], 1'b1);
                end
                default: begin
                    // dump: once around, cursor ends where it began
                    for (int i = 0; i < n; i++)
                        push_result(clce_pkg::ST_OK, ring_vals[i], logic'(i == n - 1));
                end
            endcase
        end
    endtask

    // Driver: present requests and the result ready at the falling edge
    always @(negedge i_clk) begin : drive_reqs
        t_req_item nxt;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_m_axis_tready <= 1'b0;
        end else begin
            // hold a request that has not been taken yet
            if (!i_s_axis_tvalid || req_accepted) begin
                if (pending_reqs.size() != 0 && !idle_roll() &&
                    !(pending_reqs[0].drain_first && ring_results.size() != 0)) begin
                    nxt = pending_reqs.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tuser  <= nxt.cmd;
                    i_s_axis_tdata  <= nxt.value;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
            i_m_axis_tready <= !idle_roll();
        end
    end

    // Monitor: predict on each taken request, then check each taken result
    always @(posedge i_clk) begin : watch_ports
        t_ring_result want;
        t_ring_result got;
        req_accepted = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (req_accepted) begin
            reqs_taken++;
            ring_apply(i_s_axis_tuser, i_s_axis_tdata);
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            got.status = clce_pkg::t_status'(o_m_axis_tuser);
            got.data   = o_m_axis_tdata[31:0];
            got.count  = o_m_axis_tdata[37:32];
            got.last   = o_m_axis_tlast;
            if (o_m_axis_tdata[39:38] != 2'b00)
                report_mismatch($sformatf("pad bits %b not zero", o_m_axis_tdata[39:38]));
            if (ring_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status=%0d data=%h count=%0d",
                                          got.status, got.data, got.count));
            end else begin
                want = ring_results.pop_front();
                if (got.status != want.status || got.data != want.data ||
                    got.count != want.count || got.last != want.last)
                    report_mismatch($sformatf(
                        "got st=%0d data=%h cnt=%0d last=%b, want st=%0d data=%h cnt=%0d last=%b",
                        got.status, got.data, got.count, got.last,
                        want.status, want.data, want.count, want.last));
            end
        end
    end

    task automatic add_req(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value,
                           input bit drain_first = 1'b0);
        t_req_item r;
        r.cmd = cmd;
        r.value = value;
        r.drain_first = drain_first;
        pending_reqs.push_back(r);
    endtask

    // Mostly small keys so finds and removes hit, plus extremes and full-range values
    function automatic logic [DATA_W-1:0] pick_key();
        int r;
        r = $urandom % 10;
        if (r < 7)
            return DATA_W'($urandom_range(0, 15)) - 32'd8;
        else if (r == 7)
            return ($urandom % 2) ? 32'h7fff_ffff : 32'h8000_0000;
        else
            return $urandom;
    endfunction

    // Stop the run on a hang
    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        int n_rand;
        int pick;
        int burst;
        logic [CMD_W-1:0] c;

        // directed: every command on an empty list
        add_req(clce_pkg::CMD_FIND, 32'd0);
        add_req(clce_pkg::CMD_REMOVE, 32'd0);
        add_req(clce_pkg::CMD_STEP, 32'd0);
        add_req(clce_pkg::CMD_DUMP, 32'd0);
        add_req(clce_pkg::CMD_DUMP + 3'd1, 32'hffff_ffff);
        // extremes of the value field
        add_req(clce_pkg::CMD_INSERT, 32'h7fff_ffff);
        add_req(clce_pkg::CMD_INSERT, 32'h8000_0000);
        add_req(clce_pkg::CMD_INSERT, 32'h0000_0000);
        add_req(clce_pkg::CMD_INSERT, 32'hffff_ffff);
        add_req(clce_pkg::CMD_INSERT, 32'h0000_0001);
        add_req(clce_pkg::CMD_DUMP, 32'd0);
        add_req(clce_pkg::CMD_STEP, 32'd0);
        add_req(clce_pkg::CMD_FIND, 32'hffff_ffff);
        add_req(clce_pkg::CMD_FIND, 32'd12345);
        // remove the key sitting at the cursor, then a miss
        add_req(clce_pkg::CMD_REMOVE, 32'hffff_ffff);
        add_req(clce_pkg::CMD_REMOVE, 32'h5555_5555);
        add_req(clce_pkg::CMD_DUMP + 3'd3, 32'd0);
        add_req(clce_pkg::CMD_STEP, 32'd0);
        add_req(clce_pkg::CMD_REMOVE, 32'h7fff_ffff);
        add_req(clce_pkg::CMD_REMOVE, 32'h8000_0000);
        add_req(clce_pkg::CMD_REMOVE, 32'h0000_0000);
        // removing the only element empties the list
        add_req(clce_pkg::CMD_REMOVE, 32'h0000_0001);
        add_req(clce_pkg::CMD_INSERT, 32'haaaa_aaaa);
        add_req(clce_pkg::CMD_DUMP + 3'd2, 32'h5555_5555);

        // fill past capacity, then a full-size dump; wait for the ring to settle first
        n_rand = 0;
        for (int i = 0; i < RING_CAP + 4; i++) begin
            add_req(clce_pkg::CMD_INSERT, pick_key(), i == 0);
            n_rand++;
        end
        add_req(clce_pkg::CMD_DUMP, 32'd0);
        add_req(clce_pkg::CMD_FIND, pick_key());
        n_rand += 2;

        // random segments: insert bursts, remove bursts and mixed traffic
        while (n_rand < 300) begin
            pick = $urandom % 10;
            if (pick < 2) begin
                burst = $urandom_range(10, 30);
                for (int i = 0; i < burst; i++)
                    add_req(clce_pkg::CMD_REMOVE, pick_key());
                n_rand += burst;
            end else if (pick < 4) begin
                burst = $urandom_range(5, 25);
                for (int i = 0; i < burst; i++)
                    add_req(clce_pkg::CMD_INSERT, pick_key());
                n_rand += burst;
            end else begin
                pick = $urandom % 100;
                if (pick < 30)      c = clce_pkg::CMD_INSERT;
                else if (pick < 50) c = clce_pkg::CMD_FIND;
                else if (pick < 72) c = clce_pkg::CMD_REMOVE;
                else if (pick < 84) c = clce_pkg::CMD_STEP;
                else if (pick < 95) c = clce_pkg::CMD_DUMP;
                else                c = clce_pkg::CMD_DUMP + 3'($urandom_range(1, 3));
                add_req(c, pick_key(), ($urandom % 50) == 0);
                if (c <= clce_pkg::CMD_DUMP)
                    n_rand++;
            end
        end

        // hold reset, release it away from the sampling edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // drain: every request taken and every result back
        while (pending_reqs.size() != 0 || i_s_axis_tvalid || ring_results.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        $display("%0d requests taken, %0d results checked", reqs_taken, results_seen);
        $display("ring filled to %0d entries, %0d inserts refused as full",
                 ring_peak, full_rejects);
        if (mismatches == 0 && ring_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
